/* rtl/lun_pkg.sv */
package lun_pkg;

   localparam int MAX_STEPS_DEF = 20;
   localparam int SUBSAMPLE_DEF = 2;
   localparam int FRAC_BITS_DEF = 28;

   localparam int CSR_DW = 63;
   localparam int CSR_AW = 3;

   localparam logic [CSR_AW-1:0] CSR_FOCAL_X     = 3'd0;
   localparam logic [CSR_AW-1:0] CSR_FOCAL_Y     = 3'd1;
   localparam logic [CSR_AW-1:0] CSR_CENTER_X    = 3'd2;
   localparam logic [CSR_AW-1:0] CSR_CENTER_Y    = 3'd3;
   localparam logic [CSR_AW-1:0] CSR_RADIAL_NUM  = 3'd4;
   localparam logic [CSR_AW-1:0] CSR_RADIAL_DEN  = 3'd5;
   localparam logic [CSR_AW-1:0] CSR_TANGENTIAL  = 3'd6;
   localparam logic [CSR_AW-1:0] CSR_STOP_TOL    = 3'd7;

   localparam logic [27:0] FOCAL_RST    = 28'd32768000;
   localparam logic [27:0] CENTER_X_RST = 28'd20971520;
   localparam logic [27:0] CENTER_Y_RST = 28'd15728640;
   localparam logic [15:0] STOP_TOL_RST = 16'd410;

   localparam logic signed [63:0] LIMV = 64'sh3FFF_FFFF_FFFF_FFFF;

   typedef enum logic [1:0] {
      STAT_CONV  = 2'd0,
      STAT_LIMIT = 2'd1,
      STAT_SING  = 2'd2
   } status_type;

   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_READ  = 7'b0000010,
      ST_EXEC  = 7'b0000100,
      ST_MUL   = 7'b0001000,
      ST_DIV   = 7'b0010000,
      ST_WRITE = 7'b0100000,
      ST_FIN   = 7'b1000000
   } state_type;

   typedef enum logic [3:0] {
      OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_SCL2, OP_SCL3, OP_SCL6,
      OP_CLMP, OP_TOL, OP_DET, OP_NEXT
   } op_type;

   localparam logic [5:0] R_A    = 6'd0;
   localparam logic [5:0] R_B    = 6'd1;
   localparam logic [5:0] R_XIN  = 6'd2;
   localparam logic [5:0] R_YIN  = 6'd3;
   localparam logic [5:0] R_TOL2 = 6'd4;
   localparam logic [5:0] R_R2   = 6'd5;
   localparam logic [5:0] R_PN   = 6'd6;
   localparam logic [5:0] R_PD   = 6'd7;
   localparam logic [5:0] R_KR   = 6'd8;
   localparam logic [5:0] R_FX   = 6'd9;
   localparam logic [5:0] R_FY   = 6'd10;
   localparam logic [5:0] R_T0   = 6'd11;
   localparam logic [5:0] R_T1   = 6'd12;
   localparam logic [5:0] R_T2   = 6'd13;
   localparam logic [5:0] R_T3   = 6'd14;
   localparam logic [5:0] R_T4   = 6'd15;
   localparam logic [5:0] R_T5   = 6'd16;
   localparam logic [5:0] R_T6   = 6'd17;
   localparam logic [5:0] R_T7   = 6'd18;
   localparam logic [5:0] R_T8   = 6'd19;
   localparam logic [5:0] R_T9   = 6'd20;
   localparam logic [5:0] R_T10  = 6'd21;
   localparam logic [5:0] R_T11  = 6'd22;
   localparam int RF_DEPTH = 23;

   localparam logic [5:0] S_ZERO = 6'd32;
   localparam logic [5:0] S_ONE  = 6'd33;
   localparam logic [5:0] S_PX   = 6'd34;
   localparam logic [5:0] S_PY   = 6'd35;
   localparam logic [5:0] S_CX   = 6'd36;
   localparam logic [5:0] S_CY   = 6'd37;
   localparam logic [5:0] S_FXV  = 6'd38;
   localparam logic [5:0] S_FYV  = 6'd39;
   localparam logic [5:0] S_TOLV = 6'd40;
   localparam logic [5:0] S_K1   = 6'd41;
   localparam logic [5:0] S_K2   = 6'd42;
   localparam logic [5:0] S_K3   = 6'd43;
   localparam logic [5:0] S_K4   = 6'd44;
   localparam logic [5:0] S_K5   = 6'd45;
   localparam logic [5:0] S_K6   = 6'd46;
   localparam logic [5:0] S_P1   = 6'd47;
   localparam logic [5:0] S_P2   = 6'd48;
   localparam int CST_DEPTH = 17;

   localparam int PC_W     = 7;
   localparam int PROG_LEN = 107;
   localparam logic [PC_W-1:0] PC_EVAL = 7'd8;

   typedef struct packed {
      op_type     op;
      logic [5:0] dst;
      logic [5:0] sa;
      logic [5:0] sb;
   } uop_type;

   typedef struct packed {
      logic [15:0] pixel_x;
      logic [15:0] pixel_y;
      logic        subsampled;
   } req_type;

   typedef struct packed {
      logic signed [31:0] ray_a;
      logic signed [31:0] ray_b;
      logic [1:0]         status;
      logic [4:0]         iterations;
   } rsp_type;

   function automatic uop_type ucode(logic [PC_W-1:0] pc);
      uop_type u;
      u = '{OP_NEXT, R_T0, S_ZERO, S_ZERO};
      case (pc)
         7'd0:   u = '{OP_SUB,  R_T0,   S_PX,   S_CX};
         7'd1:   u = '{OP_DIV,  R_XIN,  R_T0,   S_FXV};
         7'd2:   u = '{OP_SUB,  R_T0,   S_PY,   S_CY};
         7'd3:   u = '{OP_DIV,  R_YIN,  R_T0,   S_FYV};
         7'd4:   u = '{OP_DIV,  R_T0,   S_TOLV, S_FXV};
         7'd5:   u = '{OP_MUL,  R_TOL2, R_T0,   R_T0};
         7'd6:   u = '{OP_ADD,  R_A,    S_ZERO, S_ZERO};
         7'd7:   u = '{OP_ADD,  R_B,    S_ZERO, S_ZERO};
         7'd8:   u = '{OP_MUL,  R_T0,   R_A,    R_A};
         7'd9:   u = '{OP_MUL,  R_T1,   R_B,    R_B};
         7'd10:  u = '{OP_ADD,  R_R2,   R_T0,   R_T1};
         7'd11:  u = '{OP_MUL,  R_T2,   R_R2,   S_K3};
         7'd12:  u = '{OP_ADD,  R_T2,   S_K2,   R_T2};
         7'd13:  u = '{OP_MUL,  R_T2,   R_R2,   R_T2};
         7'd14:  u = '{OP_ADD,  R_T2,   S_K1,   R_T2};
         7'd15:  u = '{OP_MUL,  R_T2,   R_R2,   R_T2};
         7'd16:  u = '{OP_ADD,  R_PN,   S_ONE,  R_T2};
         7'd17:  u = '{OP_MUL,  R_T2,   R_R2,   S_K6};
         7'd18:  u = '{OP_ADD,  R_T2,   S_K5,   R_T2};
         7'd19:  u = '{OP_MUL,  R_T2,   R_R2,   R_T2};
         7'd20:  u = '{OP_ADD,  R_T2,   S_K4,   R_T2};
         7'd21:  u = '{OP_MUL,  R_T2,   R_R2,   R_T2};
         7'd22:  u = '{OP_ADD,  R_PD,   S_ONE,  R_T2};
         7'd23:  u = '{OP_DIV,  R_KR,   R_PN,   R_PD};
         7'd24:  u = '{OP_MUL,  R_T2,   R_A,    R_B};
         7'd25:  u = '{OP_SCL2, R_T2,   R_T2,   R_T2};
         7'd26:  u = '{OP_MUL,  R_T3,   R_A,    R_KR};
         7'd27:  u = '{OP_MUL,  R_T4,   S_P1,   R_T2};
         7'd28:  u = '{OP_ADD,  R_T3,   R_T3,   R_T4};
         7'd29:  u = '{OP_SCL2, R_T4,   R_T0,   R_T0};
         7'd30:  u = '{OP_ADD,  R_T4,   R_R2,   R_T4};
         7'd31:  u = '{OP_MUL,  R_T4,   S_P2,   R_T4};
         7'd32:  u = '{OP_ADD,  R_T3,   R_T3,   R_T4};
         7'd33:  u = '{OP_SUB,  R_FX,   R_T3,   R_XIN};
         7'd34:  u = '{OP_MUL,  R_T3,   R_B,    R_KR};
         7'd35:  u = '{OP_MUL,  R_T4,   S_P2,   R_T2};
         7'd36:  u = '{OP_ADD,  R_T3,   R_T3,   R_T4};
         7'd37:  u = '{OP_SCL2, R_T4,   R_T1,   R_T1};
         7'd38:  u = '{OP_ADD,  R_T4,   R_R2,   R_T4};
         7'd39:  u = '{OP_MUL,  R_T4,   S_P1,   R_T4};
         7'd40:  u = '{OP_ADD,  R_T3,   R_T3,   R_T4};
         7'd41:  u = '{OP_SUB,  R_FY,   R_T3,   R_YIN};
         7'd42:  u = '{OP_MUL,  R_T3,   R_FX,   R_FX};
         7'd43:  u = '{OP_MUL,  R_T4,   R_FY,   R_FY};
         7'd44:  u = '{OP_ADD,  R_T3,   R_T3,   R_T4};
         7'd45:  u = '{OP_TOL,  R_T0,   R_T3,   R_TOL2};
         7'd46:  u = '{OP_MUL,  R_T2,   S_K2,   R_R2};
         7'd47:  u = '{OP_SCL2, R_T2,   R_T2,   R_T2};
         7'd48:  u = '{OP_ADD,  R_T2,   S_K1,   R_T2};
         7'd49:  u = '{OP_MUL,  R_T3,   S_K3,   R_R2};
         7'd50:  u = '{OP_MUL,  R_T3,   R_T3,   R_R2};
         7'd51:  u = '{OP_SCL3, R_T3,   R_T3,   R_T3};
         7'd52:  u = '{OP_ADD,  R_T2,   R_T2,   R_T3};
         7'd53:  u = '{OP_SCL2, R_T5,   R_T2,   R_T2};
         7'd54:  u = '{OP_MUL,  R_T2,   S_K5,   R_R2};
         7'd55:  u = '{OP_SCL2, R_T2,   R_T2,   R_T2};
         7'd56:  u = '{OP_ADD,  R_T2,   S_K4,   R_T2};
         7'd57:  u = '{OP_MUL,  R_T3,   S_K6,   R_R2};
         7'd58:  u = '{OP_MUL,  R_T3,   R_T3,   R_R2};
         7'd59:  u = '{OP_SCL3, R_T3,   R_T3,   R_T3};
         7'd60:  u = '{OP_ADD,  R_T2,   R_T2,   R_T3};
         7'd61:  u = '{OP_SCL2, R_T6,   R_T2,   R_T2};
         7'd62:  u = '{OP_MUL,  R_T2,   R_T5,   R_PD};
         7'd63:  u = '{OP_MUL,  R_T3,   R_T6,   R_PN};
         7'd64:  u = '{OP_SUB,  R_T2,   R_T2,   R_T3};
         7'd65:  u = '{OP_MUL,  R_T3,   R_PD,   R_PD};
         7'd66:  u = '{OP_DIV,  R_T7,   R_T2,   R_T3};
         7'd67:  u = '{OP_MUL,  R_T2,   R_T0,   R_T7};
         7'd68:  u = '{OP_ADD,  R_T2,   R_KR,   R_T2};
         7'd69:  u = '{OP_MUL,  R_T3,   S_P1,   R_B};
         7'd70:  u = '{OP_SCL2, R_T3,   R_T3,   R_T3};
         7'd71:  u = '{OP_ADD,  R_T2,   R_T2,   R_T3};
         7'd72:  u = '{OP_MUL,  R_T3,   S_P2,   R_A};
         7'd73:  u = '{OP_SCL6, R_T3,   R_T3,   R_T3};
         7'd74:  u = '{OP_ADD,  R_T8,   R_T2,   R_T3};
         7'd75:  u = '{OP_MUL,  R_T2,   R_T1,   R_T7};
         7'd76:  u = '{OP_ADD,  R_T2,   R_KR,   R_T2};
         7'd77:  u = '{OP_MUL,  R_T3,   S_P2,   R_A};
         7'd78:  u = '{OP_SCL2, R_T3,   R_T3,   R_T3};
         7'd79:  u = '{OP_ADD,  R_T2,   R_T2,   R_T3};
         7'd80:  u = '{OP_MUL,  R_T3,   S_P1,   R_B};
         7'd81:  u = '{OP_SCL6, R_T3,   R_T3,   R_T3};
         7'd82:  u = '{OP_ADD,  R_T9,   R_T2,   R_T3};
         7'd83:  u = '{OP_MUL,  R_T2,   R_A,    R_B};
         7'd84:  u = '{OP_MUL,  R_T2,   R_T2,   R_T7};
         7'd85:  u = '{OP_MUL,  R_T3,   S_P1,   R_A};
         7'd86:  u = '{OP_MUL,  R_T4,   S_P2,   R_B};
         7'd87:  u = '{OP_ADD,  R_T3,   R_T3,   R_T4};
         7'd88:  u = '{OP_SCL2, R_T3,   R_T3,   R_T3};
         7'd89:  u = '{OP_ADD,  R_T10,  R_T2,   R_T3};
         7'd90:  u = '{OP_MUL,  R_T2,   R_T8,   R_T9};
         7'd91:  u = '{OP_MUL,  R_T3,   R_T10,  R_T10};
         7'd92:  u = '{OP_SUB,  R_T11,  R_T2,   R_T3};
         7'd93:  u = '{OP_DET,  R_T0,   R_T11,  R_T11};
         7'd94:  u = '{OP_MUL,  R_T2,   R_T10,  R_FY};
         7'd95:  u = '{OP_MUL,  R_T3,   R_T9,   R_FX};
         7'd96:  u = '{OP_SUB,  R_T2,   R_T2,   R_T3};
         7'd97:  u = '{OP_DIV,  R_T2,   R_T2,   R_T11};
         7'd98:  u = '{OP_ADD,  R_T2,   R_A,    R_T2};
         7'd99:  u = '{OP_CLMP, R_A,    R_T2,   R_T2};
         7'd100: u = '{OP_MUL,  R_T3,   R_T10,  R_FX};
         7'd101: u = '{OP_MUL,  R_T4,   R_T8,   R_FY};
         7'd102: u = '{OP_SUB,  R_T3,   R_T3,   R_T4};
         7'd103: u = '{OP_DIV,  R_T3,   R_T3,   R_T11};
         7'd104: u = '{OP_ADD,  R_T3,   R_B,    R_T3};
         7'd105: u = '{OP_CLMP, R_B,    R_T3,   R_T3};
         default: u = '{OP_NEXT, R_T0, S_ZERO, S_ZERO};
      endcase
      return u;
   endfunction

endpackage

/* rtl/lens_undistort_newton.sv */
// Lens undistortion: inverts a rational radial plus tangential distortion
// model by Newton-Raphson, one pixel at a time.
// req_*: one beat carries a pixel (Q12.4) and the subsampled flag; req_ready
// is high only while the block is idle.
// rsp_*: one beat per pixel with the ray (a,b) in Q3.28, status and the
// number of Newton steps taken.
// csr_*: register writes, one per cycle; write only while no pixel is in flight.
// All arithmetic runs on one shared datapath under a microcode sequencer:
// each op reads its operands, executes and writes back (a compare writes
// nothing); a product sums four 32x32 partial products, and a quotient
// comes from a 128-step restoring divider, which a zero divisor skips.
// Reset restores the register defaults and returns to idle; the register
// file needs no clearing. A finished result sits in the output register
// while rsp_ready is low; the next pixel is accepted meanwhile, and its
// result waits until the earlier beat is taken.
module lens_undistort_newton
   import lun_pkg::*;
#(
   parameter int MAX_STEPS        = MAX_STEPS_DEF,
   parameter int SUBSAMPLE_FACTOR = SUBSAMPLE_DEF,
   parameter int FRACTION_BITS    = FRAC_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  req_type           req_payload,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rsp_type           rsp_payload,
   input  logic              csr_write_en,
   input  logic [CSR_AW-1:0] csr_index,
   input  logic [CSR_DW-1:0] csr_wdata
);

   localparam int CW  = $clog2(MAX_STEPS + 1);
   localparam int PXW = 16 + $clog2(SUBSAMPLE_FACTOR + 1);
   localparam int FB  = FRACTION_BITS;
   localparam logic signed [63:0] ONE_V     = 64'sd1 <<< FB;
   localparam logic signed [63:0] CLAMP_TOP = (64'sd1 <<< (FB + 3)) - 64'sd1;
   localparam logic signed [63:0] CLAMP_BOT = -CLAMP_TOP - 64'sd1;
   localparam longint LIM_RAW = ((longint'(1) << FB) + 64'sd500000000000)
                                / 64'sd1000000000000;
   localparam logic signed [63:0] LIM_V = (LIM_RAW < 1) ? 64'sd1 : 64'(LIM_RAW);
   localparam int OSH = (FB > 28) ? FB - 28 : 0;
   localparam int OUP = (FB < 28) ? 28 - FB : 0;
   localparam logic [63:0] ORND = (OSH > 0) ? (64'd1 << (OSH - 1)) : 64'd0;

   function automatic logic signed [63:0] sat68(logic signed [67:0] v);
      logic signed [63:0] r;
      if (v > 68'(LIMV)) r = LIMV;
      else if (v < -68'(LIMV)) r = -LIMV;
      else r = v[63:0];
      return r;
   endfunction

   function automatic logic [63:0] mag64(logic signed [63:0] v);
      logic [63:0] r;
      r = v[63] ? 64'(-v) : 64'(v);
      return r;
   endfunction

   function automatic logic [31:0] outray(logic signed [63:0] v);
      logic [63:0]        m;
      logic signed [63:0] r;
      logic [31:0]        o;
      m = ((mag64(v) + ORND) >> OSH) << OUP;
      r = v[63] ? -$signed(m) : $signed(m);
      if (r > 64'sd2147483647) o = 32'h7FFF_FFFF;
      else if (r < -64'sd2147483648) o = 32'h8000_0000;
      else o = r[31:0];
      return o;
   endfunction

   // configuration registers
   logic [27:0] fx_ff, fy_ff, cx_ff, cy_ff;
   logic [62:0] num_ff, den_ff;
   logic [39:0] tan_ff;
   logic [15:0] tol_ff;

   state_type        state_ff, state_in;
   logic [PC_W-1:0]  pc_ff, pc_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic [2:0]       mcnt_ff;
   logic [6:0]       dcnt_ff;
   logic             rsp_valid_ff;
   logic [1:0]       status_ff, status_in;
   logic [CW-1:0]    steps_ff, steps_in;
   rsp_type          rsp_ff;

   logic [PXW-1:0]     px_ff, py_ff;
   logic signed [63:0] op_a_ff, op_b_ff, res_ff, a_ff, b_ff;
   logic signed [63:0] rf_mem [RF_DEPTH];
   logic [63:0]        mag_a_ff, mag_b_ff, pp_ff;
   logic [1:0]         psh_ff;
   logic [127:0]       acc_ff, dvd_ff;
   logic [63:0]        drem_ff, dud_ff, dq_ff;
   logic               dover_ff, neg_ff;

   uop_type            uop;
   logic signed [63:0] cst_tab [CST_DEPTH];
   logic signed [63:0] cst_a, cst_b;
   logic signed [63:0] alu_res, mul_out, div_out, wb_val;
   logic signed [67:0] ea, eb, a3;
   logic [63:0]        q_mul, ua, ub, qn, rem2;
   logic               mul_over, conv, sing, ge, load_rsp, req_take, div_zero;
   logic [31:0]        ca, cb;

   assign uop       = ucode(pc_ff);
   assign req_ready = (state_ff == ST_IDLE);
   assign req_take  = req_valid && req_ready;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;
   assign load_rsp  = (state_ff == ST_FIN) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      cst_tab[0]  = '0;
      cst_tab[1]  = ONE_V;
      cst_tab[2]  = $signed(64'(px_ff) << (FB - 4));
      cst_tab[3]  = $signed(64'(py_ff) << (FB - 4));
      cst_tab[4]  = $signed(64'(cx_ff) << (FB - 16));
      cst_tab[5]  = $signed(64'(cy_ff) << (FB - 16));
      cst_tab[6]  = $signed(64'(fx_ff) << (FB - 16));
      cst_tab[7]  = $signed(64'(fy_ff) << (FB - 16));
      cst_tab[8]  = $signed(64'(tol_ff) << (FB - 12));
      cst_tab[9]  = 64'($signed(num_ff[20:0])) <<< (FB - 19);
      cst_tab[10] = 64'($signed(num_ff[41:21])) <<< (FB - 19);
      cst_tab[11] = 64'($signed(num_ff[62:42])) <<< (FB - 19);
      cst_tab[12] = 64'($signed(den_ff[20:0])) <<< (FB - 19);
      cst_tab[13] = 64'($signed(den_ff[41:21])) <<< (FB - 19);
      cst_tab[14] = 64'($signed(den_ff[62:42])) <<< (FB - 19);
      cst_tab[15] = 64'($signed(tan_ff[19:0])) <<< (FB - 19);
      cst_tab[16] = 64'($signed(tan_ff[39:20])) <<< (FB - 19);
   end

   assign cst_a = cst_tab[uop.sa[4:0]];
   assign cst_b = cst_tab[uop.sb[4:0]];

   // combinational ALU for the simple ops
   always_comb begin
      ea = 68'(op_a_ff);
      eb = 68'(op_b_ff);
      a3 = ea + (ea <<< 1);
      case (uop.op)
         OP_ADD:  alu_res = sat68(ea + eb);
         OP_SUB:  alu_res = sat68(ea - eb);
         OP_SCL2: alu_res = sat68(ea <<< 1);
         OP_SCL3: alu_res = sat68(a3);
         OP_SCL6: alu_res = sat68(a3 <<< 1);
         OP_CLMP: begin
            if (op_a_ff > CLAMP_TOP) alu_res = CLAMP_TOP;
            else if (op_a_ff < CLAMP_BOT) alu_res = CLAMP_BOT;
            else alu_res = op_a_ff;
         end
         default: alu_res = op_a_ff;
      endcase
   end

   assign ua       = mag64(op_a_ff);
   assign ub       = mag64(op_b_ff);
   assign div_zero = (op_b_ff == 64'sd0);
   assign conv     = (op_a_ff < op_b_ff);
   assign sing     = (op_a_ff < LIM_V) && (op_a_ff > -LIM_V);

   assign ca = mcnt_ff[0] ? mag_a_ff[63:32] : mag_a_ff[31:0];
   assign cb = mcnt_ff[1] ? mag_b_ff[63:32] : mag_b_ff[31:0];

   always_comb begin
      mul_over = |acc_ff[127:64+FB];
      q_mul    = acc_ff[63+FB:FB];
      if (mul_over || (q_mul > 64'(LIMV))) q_mul = 64'(LIMV);
      mul_out  = neg_ff ? -$signed(q_mul) : $signed(q_mul);
      div_out  = dover_ff ? (neg_ff ? -LIMV : LIMV)
                          : (neg_ff ? -$signed(dq_ff) : $signed(dq_ff));
      rem2     = {drem_ff[62:0], dvd_ff[127]};
      ge       = (rem2 >= dud_ff);
      qn       = {dq_ff[62:0], ge};
      case (uop.op)
         OP_MUL:  wb_val = mul_out;
         OP_DIV:  wb_val = div_out;
         default: wb_val = res_ff;
      endcase
   end

   // datapath
   always_ff @(posedge clock) begin
      if (req_take) begin
         px_ff <= PXW'(req_payload.pixel_x)
                  * PXW'(req_payload.subsampled ? SUBSAMPLE_FACTOR : 1);
         py_ff <= PXW'(req_payload.pixel_y)
                  * PXW'(req_payload.subsampled ? SUBSAMPLE_FACTOR : 1);
      end
      if (state_ff == ST_READ) begin
         op_a_ff <= uop.sa[5] ? cst_a : rf_mem[uop.sa[4:0]];
         op_b_ff <= uop.sb[5] ? cst_b : rf_mem[uop.sb[4:0]];
      end
      if (state_ff == ST_EXEC) begin
         res_ff   <= alu_res;
         neg_ff   <= op_a_ff[63] ^ op_b_ff[63];
         mag_a_ff <= ua;
         mag_b_ff <= ub;
         acc_ff   <= 128'd1 << (FB - 1);
         dud_ff   <= ub;
         dvd_ff   <= ({64'd0, ua} << FB) + {64'd0, ub >> 1};
         drem_ff  <= '0;
         dq_ff    <= '0;
         dover_ff <= div_zero && (op_a_ff != 64'sd0);
      end
      if (state_ff == ST_MUL) begin
         pp_ff  <= ca * cb;
         psh_ff <= 2'(mcnt_ff[0]) + 2'(mcnt_ff[1]);
         if (mcnt_ff != 3'd0) acc_ff <= acc_ff + ({64'd0, pp_ff} << {psh_ff, 5'd0});
      end
      if (state_ff == ST_DIV) begin
         dvd_ff  <= dvd_ff << 1;
         drem_ff <= ge ? rem2 - dud_ff : rem2;
         if (!dover_ff) begin
            dq_ff <= qn;
            if (qn > 64'(LIMV)) dover_ff <= 1'b1;
         end
      end
      if (state_ff == ST_WRITE) begin
         rf_mem[uop.dst[4:0]] <= wb_val;
         if (uop.dst == R_A) a_ff <= wb_val;
         if (uop.dst == R_B) b_ff <= wb_val;
      end
      if (load_rsp) begin
         rsp_ff.ray_a      <= outray(a_ff);
         rsp_ff.ray_b      <= outray(b_ff);
         rsp_ff.status     <= status_ff;
         rsp_ff.iterations <= 5'(steps_ff);
      end
   end

   // sequencer
   always_comb begin
      state_in  = state_ff;
      pc_in     = pc_ff;
      cnt_in    = cnt_ff;
      status_in = status_ff;
      steps_in  = steps_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               state_in = ST_READ;
               pc_in    = '0;
               cnt_in   = '0;
            end
         end
         ST_READ: state_in = ST_EXEC;
         ST_EXEC: begin
            case (uop.op)
               OP_MUL: state_in = ST_MUL;
               OP_DIV: state_in = div_zero ? ST_WRITE : ST_DIV;
               OP_TOL: begin
                  if (conv) begin
                     state_in  = ST_FIN;
                     status_in = STAT_CONV;
                     steps_in  = cnt_ff;
                  end else if (cnt_ff == CW'(MAX_STEPS)) begin
                     state_in  = ST_FIN;
                     status_in = STAT_LIMIT;
                     steps_in  = cnt_ff;
                  end else begin
                     state_in = ST_READ;
                     pc_in    = pc_ff + 1'b1;
                  end
               end
               OP_DET: begin
                  if (sing) begin
                     state_in  = ST_FIN;
                     status_in = STAT_SING;
                     steps_in  = cnt_ff;
                  end else begin
                     state_in = ST_READ;
                     pc_in    = pc_ff + 1'b1;
                  end
               end
               OP_NEXT: begin
                  state_in = ST_READ;
                  pc_in    = PC_EVAL;
                  cnt_in   = cnt_ff + 1'b1;
               end
               default: state_in = ST_WRITE;
            endcase
         end
         ST_MUL:   if (mcnt_ff == 3'd4) state_in = ST_WRITE;
         ST_DIV:   if (dcnt_ff == 7'd127) state_in = ST_WRITE;
         ST_WRITE: begin
            state_in = ST_READ;
            pc_in    = pc_ff + 1'b1;
         end
         ST_FIN:   if (load_rsp) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pc_ff        <= '0;
         cnt_ff       <= '0;
         mcnt_ff      <= '0;
         dcnt_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         status_ff    <= STAT_CONV;
         steps_ff     <= '0;
         fx_ff        <= FOCAL_RST;
         fy_ff        <= FOCAL_RST;
         cx_ff        <= CENTER_X_RST;
         cy_ff        <= CENTER_Y_RST;
         num_ff       <= '0;
         den_ff       <= '0;
         tan_ff       <= '0;
         tol_ff       <= STOP_TOL_RST;
      end else begin
         state_ff  <= state_in;
         pc_ff     <= pc_in;
         cnt_ff    <= cnt_in;
         status_ff <= status_in;
         steps_ff  <= steps_in;
         mcnt_ff   <= (state_ff == ST_MUL) ? mcnt_ff + 1'b1 : 3'd0;
         dcnt_ff   <= (state_ff == ST_DIV) ? dcnt_ff + 1'b1 : 7'd0;
         if (load_rsp) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
         if (csr_write_en) begin
            unique case (csr_index)
               CSR_FOCAL_X:    fx_ff  <= csr_wdata[27:0];
               CSR_FOCAL_Y:    fy_ff  <= csr_wdata[27:0];
               CSR_CENTER_X:   cx_ff  <= csr_wdata[27:0];
               CSR_CENTER_Y:   cy_ff  <= csr_wdata[27:0];
               CSR_RADIAL_NUM: num_ff <= csr_wdata;
               CSR_RADIAL_DEN: den_ff <= csr_wdata;
               CSR_TANGENTIAL: tan_ff <= csr_wdata[39:0];
               CSR_STOP_TOL:   tol_ff <= csr_wdata[15:0];
               default: ;
            endcase
         end
      end
   end

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      req_take |=> (state_ff == ST_READ) && (pc_ff == '0))
      else $error("accepted beat did not start the program");

   a_step_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(MAX_STEPS))
      else $error("step count beyond limit");

   a_pc_bound: assert property (@(posedge clock) disable iff (reset)
      pc_ff < PC_W'(PROG_LEN))
      else $error("sequencer ran off the program");

   a_fin_load: assert property (@(posedge clock) disable iff (reset)
      load_rsp |=> rsp_valid_ff && (state_ff == ST_IDLE))
      else $error("finished result not loaded");

endmodule

/* sim/lens_undistort_newton_test.sv */
`timescale 1ns / 100ps

module lens_undistort_newton_test;
   import lun_pkg::*;

   typedef logic signed [127:0] wide_t;

   localparam int IDLE_LIMIT = 200000;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   req_type           req_payload = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   rsp_type           rsp_payload;
   logic              csr_write_en = 1'b0;
   logic [CSR_AW-1:0] csr_index = CSR_FOCAL_X;
   logic [CSR_DW-1:0] csr_wdata = '0;

   logic [63:0] cfg_focal_x, cfg_focal_y, cfg_center_x, cfg_center_y;
   logic [63:0] cfg_num, cfg_den, cfg_tan, cfg_tol;
   longint      k1, k2, k3, k4, k5, k6, p1, p2;

   rsp_type ray_queue[$];
   int      errors = 0;
   int      idle_cycles = 0;
   bit      sender_steady = 1'b0;
   bit      receiver_steady = 1'b0;

   lens_undistort_newton u_dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_payload  (req_payload),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_payload  (rsp_payload),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   function automatic longint fx_sat(wide_t v);
      if (v > LIMV) return LIMV;
      if (v < -LIMV) return -LIMV;
      return v[63:0];
   endfunction

   function automatic longint fx_add(longint x, longint y);
      wide_t wx, wy;
      wx = x;
      wy = y;
      return fx_sat(wx + wy);
   endfunction

   function automatic longint fx_sub(longint x, longint y);
      wide_t wx, wy;
      wx = x;
      wy = y;
      return fx_sat(wx - wy);
   endfunction

   function automatic longint fx_scale(longint x, int n);
      wide_t wx, wn;
      wx = x;
      wn = n;
      return fx_sat(wx * wn);
   endfunction

   function automatic logic [127:0] fx_mag(longint x);
      wide_t w;
      w = x;
      return (w < 0) ? -w : w;
   endfunction

   function automatic longint fx_mul(longint x, longint y);
      logic [127:0] p;
      longint       r;
      p = (fx_mag(x) * fx_mag(y) + (128'd1 << 27)) >> 28;
      if (p > 128'(LIMV)) p = 128'(LIMV);
      r = p[63:0];
      return ((x < 0) != (y < 0)) ? -r : r;
   endfunction

   function automatic longint fx_div(longint n, longint d);
      logic [127:0] q;
      longint       r;
      if (d == 0) return (n > 0) ? LIMV : ((n < 0) ? -LIMV : 64'sd0);
      q = ((fx_mag(n) << 28) + (fx_mag(d) >> 1)) / fx_mag(d);
      if (q > 128'(LIMV)) q = 128'(LIMV);
      r = q[63:0];
      return ((n < 0) != (d < 0)) ? -r : r;
   endfunction

   function automatic longint coef_field(logic [63:0] word, int pos, int bits);
      logic [63:0] f;
      longint      raw;
      f = (word >> pos) & ((64'd1 << bits) - 64'd1);
      raw = f;
      if (f[bits-1]) raw = raw - (longint'(1) << bits);
      return raw * 512;
   endfunction

   function automatic void residual(input longint a, b, xin, yin,
                                    output longint r2, pn, pd, kr, fx, fy);
      longint kab;
      r2 = fx_add(fx_mul(a, a), fx_mul(b, b));
      pn = fx_add(64'sd1 << 28, fx_mul(r2, fx_add(k1, fx_mul(r2, fx_add(k2, fx_mul(r2, k3))))));
      pd = fx_add(64'sd1 << 28, fx_mul(r2, fx_add(k4, fx_mul(r2, fx_add(k5, fx_mul(r2, k6))))));
      kr = fx_div(pn, pd);
      kab = fx_scale(fx_mul(a, b), 2);
      fx = fx_sub(fx_add(fx_add(fx_mul(a, kr), fx_mul(p1, kab)),
                         fx_mul(p2, fx_add(r2, fx_scale(fx_mul(a, a), 2)))), xin);
      fy = fx_sub(fx_add(fx_add(fx_mul(b, kr), fx_mul(p2, kab)),
                         fx_mul(p1, fx_add(r2, fx_scale(fx_mul(b, b), 2)))), yin);
   endfunction

   function automatic longint clamp_ray(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic rsp_type undistort(req_type rq);
      longint     px, py, xin, yin, t, tol2, a, b, r2, pn, pd, kr, fx, fy;
      longint     c1, c2, c3, jxa, jyb, jxb, det, da, db;
      status_type st;
      int         steps;
      rsp_type    r;
      px = longint'(rq.pixel_x) * (rq.subsampled ? 2 : 1);
      py = longint'(rq.pixel_y) * (rq.subsampled ? 2 : 1);
      xin = fx_div(fx_sub(px << 24, cfg_center_x << 12), cfg_focal_x << 12);
      yin = fx_div(fx_sub(py << 24, cfg_center_y << 12), cfg_focal_y << 12);
      t = fx_div(cfg_tol << 16, cfg_focal_x << 12);
      tol2 = fx_mul(t, t);
      k1 = coef_field(cfg_num, 0, 21);
      k2 = coef_field(cfg_num, 21, 21);
      k3 = coef_field(cfg_num, 42, 21);
      k4 = coef_field(cfg_den, 0, 21);
      k5 = coef_field(cfg_den, 21, 21);
      k6 = coef_field(cfg_den, 42, 21);
      p1 = coef_field(cfg_tan, 0, 20);
      p2 = coef_field(cfg_tan, 20, 20);
      a = 0;
      b = 0;
      st = STAT_LIMIT;
      steps = MAX_STEPS_DEF;
      residual(a, b, xin, yin, r2, pn, pd, kr, fx, fy);
      if (fx_add(fx_mul(fx, fx), fx_mul(fy, fy)) < tol2) begin
         st = STAT_CONV;
         steps = 0;
      end else begin
         for (int s = 1; s <= MAX_STEPS_DEF; s++) begin
            c1 = fx_scale(fx_add(fx_add(k1, fx_scale(fx_mul(k2, r2), 2)),
                                 fx_scale(fx_mul(fx_mul(k3, r2), r2), 3)), 2);
            c2 = fx_scale(fx_add(fx_add(k4, fx_scale(fx_mul(k5, r2), 2)),
                                 fx_scale(fx_mul(fx_mul(k6, r2), r2), 3)), 2);
            c3 = fx_div(fx_sub(fx_mul(c1, pd), fx_mul(c2, pn)), fx_mul(pd, pd));
            jxa = fx_add(fx_add(fx_add(kr, fx_mul(fx_mul(a, a), c3)),
                                fx_scale(fx_mul(p1, b), 2)), fx_scale(fx_mul(p2, a), 6));
            jyb = fx_add(fx_add(fx_add(kr, fx_mul(fx_mul(b, b), c3)),
                                fx_scale(fx_mul(p2, a), 2)), fx_scale(fx_mul(p1, b), 6));
            jxb = fx_add(fx_mul(fx_mul(a, b), c3),
                         fx_scale(fx_add(fx_mul(p1, a), fx_mul(p2, b)), 2));
            det = fx_sub(fx_mul(jxa, jyb), fx_mul(jxb, jxb));
            if (det == 0) begin
               st = STAT_SING;
               steps = s - 1;
               break;
            end
            da = fx_div(fx_sub(fx_mul(jxb, fy), fx_mul(jyb, fx)), det);
            db = fx_div(fx_sub(fx_mul(jxb, fx), fx_mul(jxa, fy)), det);
            a = clamp_ray(fx_add(a, da));
            b = clamp_ray(fx_add(b, db));
            residual(a, b, xin, yin, r2, pn, pd, kr, fx, fy);
            if (fx_add(fx_mul(fx, fx), fx_mul(fy, fy)) < tol2) begin
               st = STAT_CONV;
               steps = s;
               break;
            end
         end
      end
      r.ray_a = a[31:0];
      r.ray_b = b[31:0];
      r.status = st;
      r.iterations = steps[4:0];
      return r;
   endfunction

   function automatic int draw_wait(bit steady);
      return steady ? 0 : $urandom_range(0, 18);
   endfunction

   task automatic send_pixel(logic [15:0] px, logic [15:0] py, logic sub);
      int gap;
      req_type rq;
      gap = draw_wait(sender_steady);
      rq.pixel_x = px;
      rq.pixel_y = py;
      rq.subsampled = sub;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= rq;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      ray_queue.push_back(undistort(rq));
   endtask

   task automatic drain;
      req_valid <= 1'b0;
      @(posedge clock);
      while (ray_queue.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic csr_write(logic [CSR_AW-1:0] idx, logic [63:0] data);
      @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data[CSR_DW-1:0];
      case (idx)
         CSR_FOCAL_X:    cfg_focal_x  = data & 64'hFFFFFFF;
         CSR_FOCAL_Y:    cfg_focal_y  = data & 64'hFFFFFFF;
         CSR_CENTER_X:   cfg_center_x = data & 64'hFFFFFFF;
         CSR_CENTER_Y:   cfg_center_y = data & 64'hFFFFFFF;
         CSR_RADIAL_NUM: cfg_num      = data & 64'h7FFFFFFFFFFFFFFF;
         CSR_RADIAL_DEN: cfg_den      = data & 64'h7FFFFFFFFFFFFFFF;
         CSR_TANGENTIAL: cfg_tan      = data & 64'hFFFFFFFFFF;
         CSR_STOP_TOL:   cfg_tol      = data & 64'hFFFF;
         default: ;
      endcase
      @(posedge clock);
      csr_write_en <= 1'b0;
   endtask

   task automatic load_lens(logic [63:0] fx, fy, cx, cy, num, den, tan, tol);
      csr_write(CSR_FOCAL_X, fx);
      csr_write(CSR_FOCAL_Y, fy);
      csr_write(CSR_CENTER_X, cx);
      csr_write(CSR_CENTER_Y, cy);
      csr_write(CSR_RADIAL_NUM, num);
      csr_write(CSR_RADIAL_DEN, den);
      csr_write(CSR_TANGENTIAL, tan);
      csr_write(CSR_STOP_TOL, tol);
   endtask

   function automatic logic [63:0] pack_radial(int c1, int c2, int c3);
      logic [20:0] f1, f2, f3;
      f1 = c1[20:0];
      f2 = c2[20:0];
      f3 = c3[20:0];
      return {1'b0, f3, f2, f1};
   endfunction

   function automatic logic [63:0] pack_tangential(int t1, int t2);
      logic [19:0] f1, f2;
      f1 = t1[19:0];
      f2 = t2[19:0];
      return {24'd0, f2, f1};
   endfunction

   function automatic int rnd_signed(int m);
      return int'($urandom_range(0, 2 * m)) - m;
   endfunction

   task automatic load_random_lens(bit wild);
      if (wild)
         load_lens({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                   {$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                   {$urandom, $urandom}, {$urandom, $urandom});
      else
         load_lens(64'($urandom_range(150, 1500)) << 16, 64'($urandom_range(150, 1500)) << 16,
                   64'($urandom_range(0, 1279)) << 16, 64'($urandom_range(0, 959)) << 16,
                   pack_radial(rnd_signed(200000), rnd_signed(60000), rnd_signed(20000)),
                   pack_radial(rnd_signed(100000), rnd_signed(30000), rnd_signed(10000)),
                   pack_tangential(rnd_signed(8000), rnd_signed(8000)),
                   64'($urandom_range(0, 4095)));
   endtask

   task automatic test_defaults;
      send_pixel(16'd0, 16'd0, 1'b0);
      send_pixel(16'hFFFF, 16'hFFFF, 1'b1);
      send_pixel(16'hFFFF, 16'd0, 1'b0);
      send_pixel(16'd0, 16'hFFFF, 1'b1);
      send_pixel(16'd5120, 16'd3840, 1'b0);
      send_pixel(16'd2560, 16'd1920, 1'b1);
      send_pixel(16'h5555, 16'hAAAA, 1'b0);
      send_pixel(16'hAAAA, 16'h5555, 1'b1);
      drain();
   endtask

   task automatic test_special_cases;
      // k1 = -1 drives the numerator to zero at r2 = 1: singular after one step
      load_lens(64'd32768000, 64'd32768000, 64'd20971520, 64'd15728640,
                pack_radial(-524288, 0, 0), 64'd0, 64'd0, 64'd410);
      send_pixel(16'd13120, 16'd3840, 1'b0);
      send_pixel(16'd6560, 16'd1920, 1'b1);
      drain();
      // denominator vanishes at r2 = 1
      csr_write(CSR_RADIAL_NUM, 64'd0);
      csr_write(CSR_RADIAL_DEN, pack_radial(-524288, 0, 0));
      send_pixel(16'd13120, 16'd3840, 1'b0);
      send_pixel(16'd9000, 16'd5000, 1'b0);
      drain();
      // zero tolerance never converges
      load_lens(64'd32768000, 64'd32768000, 64'd20971520, 64'd15728640,
                pack_radial(50000, -10000, 2000), pack_radial(20000, 0, 0),
                pack_tangential(3000, -3000), 64'd0);
      send_pixel(16'd9000, 16'd5000, 1'b0);
      send_pixel(16'd5120, 16'd3840, 1'b0);
      drain();
      // zero focal lengths
      load_lens(64'd0, 64'd0, 64'd0, 64'd0, 64'd0, 64'd0, 64'd0, 64'hFFFF);
      send_pixel(16'd100, 16'd0, 1'b0);
      send_pixel(16'd0, 16'd0, 1'b1);
      drain();
      // every register at its top
      load_lens('1, '1, '1, '1, '1, '1, '1, '1);
      send_pixel(16'hFFFF, 16'hFFFF, 1'b1);
      send_pixel(16'd0, 16'd0, 1'b0);
      drain();
      // coefficients at their negative extremes
      load_lens(64'd65536, 64'd65536, 64'd0, 64'd0,
                pack_radial(-1048576, -1048576, -1048576),
                pack_radial(-1048576, -1048576, -1048576),
                pack_tangential(-524288, -524288), 64'd1);
      send_pixel(16'd16, 16'd16, 1'b0);
      send_pixel(16'hFFFF, 16'd8, 1'b1);
      drain();
   endtask

   task automatic test_random_lenses;
      for (int phase = 0; phase < 12; phase++) begin
         load_random_lens(phase == 11);
         for (int i = 0; i < ((phase == 11) ? 25 : 60); i++) begin
            if (i % 20 == 0) begin
               sender_steady = ($urandom_range(0, 3) == 0);
               receiver_steady = ($urandom_range(0, 3) == 0);
            end
            if (i == 30) drain();
            if ($urandom_range(0, 7) == 0)
               send_pixel(16'($urandom), 16'($urandom), 1'($urandom));
            else
               send_pixel(16'($urandom_range(0, 20479)), 16'($urandom_range(0, 15359)),
                          1'($urandom_range(0, 1)));
         end
         drain();
      end
   endtask

   initial begin
      forever begin
         int stall;
         stall = draw_wait(receiver_steady);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (ray_queue.size() == 0) begin
            errors++;
            $display("%0t: unexpected beat %p", $time, rsp_payload);
         end else begin
            want = ray_queue.pop_front();
            if (rsp_payload.ray_a !== want.ray_a) begin
               errors++;
               $display("%0t: ray_a expected %0d actual %0d", $time, want.ray_a,
                        rsp_payload.ray_a);
            end
            if (rsp_payload.ray_b !== want.ray_b) begin
               errors++;
               $display("%0t: ray_b expected %0d actual %0d", $time, want.ray_b,
                        rsp_payload.ray_b);
            end
            if (rsp_payload.status !== want.status) begin
               errors++;
               $display("%0t: status expected %0d actual %0d", $time, want.status,
                        rsp_payload.status);
            end
            if (rsp_payload.iterations !== want.iterations) begin
               errors++;
               $display("%0t: iterations expected %0d actual %0d", $time, want.iterations,
                        rsp_payload.iterations);
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("lens_undistort_newton_test: FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      cfg_focal_x = FOCAL_RST;
      cfg_focal_y = FOCAL_RST;
      cfg_center_x = CENTER_X_RST;
      cfg_center_y = CENTER_Y_RST;
      cfg_num = 0;
      cfg_den = 0;
      cfg_tan = 0;
      cfg_tol = STOP_TOL_RST;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_defaults();
      test_special_cases();
      test_random_lenses();
      drain();
      repeat (50) @(posedge clock);
      if (errors == 0)
         $display("lens_undistort_newton_test: PASS");
      else
         $display("lens_undistort_newton_test: FAIL");
      $finish;
   end

endmodule

/* sim.f */
rtl/lun_pkg.sv
rtl/lens_undistort_newton.sv
sim/lens_undistort_newton_test.sv
